[hw/rtl/c65x_pkg.sv]
`timescale 1ns / 1ps
package c65x_pkg;

   typedef logic [5:0] func_type;

   localparam func_type OP_LDA     = 6'd0;
   localparam func_type OP_LDX     = 6'd1;
   localparam func_type OP_LDY     = 6'd2;
   localparam func_type OP_STA     = 6'd3;
   localparam func_type OP_STX     = 6'd4;
   localparam func_type OP_STY     = 6'd5;
   localparam func_type OP_TAX     = 6'd6;
   localparam func_type OP_TAY     = 6'd7;
   localparam func_type OP_TXA     = 6'd8;
   localparam func_type OP_TYA     = 6'd9;
   localparam func_type OP_TSX     = 6'd10;
   localparam func_type OP_TXS     = 6'd11;
   localparam func_type OP_PHA     = 6'd12;
   localparam func_type OP_PHP     = 6'd13;
   localparam func_type OP_PLA     = 6'd14;
   localparam func_type OP_PLP     = 6'd15;
   localparam func_type OP_AND     = 6'd16;
   localparam func_type OP_EOR     = 6'd17;
   localparam func_type OP_ORA     = 6'd18;
   localparam func_type OP_BIT     = 6'd19;
   localparam func_type OP_ADC     = 6'd20;
   localparam func_type OP_SBC     = 6'd21;
   localparam func_type OP_CMP     = 6'd22;
   localparam func_type OP_CPX     = 6'd23;
   localparam func_type OP_CPY     = 6'd24;
   localparam func_type OP_INC     = 6'd25;
   localparam func_type OP_INX     = 6'd26;
   localparam func_type OP_INY     = 6'd27;
   localparam func_type OP_DEC     = 6'd28;
   localparam func_type OP_DEX     = 6'd29;
   localparam func_type OP_DEY     = 6'd30;
   localparam func_type OP_ASL_A   = 6'd31;
   localparam func_type OP_ASL_M   = 6'd32;
   localparam func_type OP_LSR_A   = 6'd33;
   localparam func_type OP_LSR_M   = 6'd34;
   localparam func_type OP_ROL_A   = 6'd35;
   localparam func_type OP_ROL_M   = 6'd36;
   localparam func_type OP_ROR_A   = 6'd37;
   localparam func_type OP_ROR_M   = 6'd38;
   localparam func_type OP_JMP     = 6'd39;
   localparam func_type OP_BCC     = 6'd40;
   localparam func_type OP_BCS     = 6'd41;
   localparam func_type OP_BEQ     = 6'd42;
   localparam func_type OP_BMI     = 6'd43;
   localparam func_type OP_BNE     = 6'd44;
   localparam func_type OP_BPL     = 6'd45;
   localparam func_type OP_BVC     = 6'd46;
   localparam func_type OP_BVS     = 6'd47;
   localparam func_type OP_CLC     = 6'd48;
   localparam func_type OP_CLD     = 6'd49;
   localparam func_type OP_CLI     = 6'd50;
   localparam func_type OP_CLV     = 6'd51;
   localparam func_type OP_SEC     = 6'd52;
   localparam func_type OP_SED     = 6'd53;
   localparam func_type OP_SEI     = 6'd54;
   localparam func_type OP_NOP     = 6'd55;

   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_D = 3;
   localparam int FL_B = 4;
   localparam int FL_U = 5;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   localparam logic [7:0] SP_RESET     = 8'hFD;
   localparam logic [7:0] STATUS_RESET = 8'h24;
   localparam logic [7:0] PUSH_BITS    = 8'h30;
   localparam logic [7:0] PULL_MASK    = 8'hCF;

   localparam logic [1:0] EXTRA_TAKEN = 2'd1;
   localparam logic [1:0] EXTRA_PAGE  = 2'd2;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] xreg;
      logic [7:0] yreg;
      logic [7:0] stack_ptr;
      logic [7:0] status;
   } regs_type;

   typedef struct packed {
      logic        mem_write;
      logic        mem_write_to_stack;
      logic [7:0]  mem_data;
      logic        pc_load;
      logic [15:0] pc_next;
      logic [1:0]  extra_cycles;
   } effect_type;

   function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r       = p;
      r[FL_Z] = (v == 8'd0);
      r[FL_N] = v[7];
      return r;
   endfunction

endpackage

[hw/rtl/c65x_alu.sv]
`timescale 1ns / 1ps
module c65x_alu
   import c65x_pkg::*;
(
   input  func_type         func,
   input  logic [15:0]      operand,
   input  logic signed [7:0] branch_offset,
   input  logic [15:0]      pc_now,
   input  regs_type         regs_cur,
   output regs_type         regs_nxt,
   output effect_type       effect
);

   logic [7:0]  m;
   logic [7:0]  p;
   logic [7:0]  add_m;
   logic [8:0]  add_sum;
   logic        add_v;
   logic [7:0]  cmp_reg;
   logic [8:0]  cmp_diff;
   logic [7:0]  sh_in;
   logic [7:0]  sh_res;
   logic        sh_cout;
   logic [15:0] br_target;
   logic        take;

   assign m = operand[7:0];
   assign p = regs_cur.status;

   assign add_m   = (func == OP_SBC) ? ~m : m;
   assign add_sum = {1'b0, regs_cur.acc} + {1'b0, add_m} + {8'd0, p[FL_C]};
   assign add_v   = ~(regs_cur.acc[7] ^ add_m[7]) & (regs_cur.acc[7] ^ add_sum[7]);

   always_comb begin
      case (func)
         OP_CPX:  cmp_reg = regs_cur.xreg;
         OP_CPY:  cmp_reg = regs_cur.yreg;
         default: cmp_reg = regs_cur.acc;
      endcase
   end

   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

   assign sh_in = func[0] ? regs_cur.acc : m;

   always_comb begin
      case (func)
         OP_ASL_A, OP_ASL_M: begin
            sh_res  = {sh_in[6:0], 1'b0};
            sh_cout = sh_in[7];
         end
         OP_ROL_A, OP_ROL_M: begin
            sh_res  = {sh_in[6:0], p[FL_C]};
            sh_cout = sh_in[7];
         end
         OP_LSR_A, OP_LSR_M: begin
            sh_res  = {1'b0, sh_in[7:1]};
            sh_cout = sh_in[0];
         end
         default: begin
            sh_res  = {p[FL_C], sh_in[7:1]};
            sh_cout = sh_in[0];
         end
      endcase
   end

   assign br_target = pc_now + {{8{branch_offset[7]}}, branch_offset};

   always_comb begin
      regs_nxt = regs_cur;
      effect   = '0;
      take     = 1'b0;
      unique case (func)
         OP_LDA: begin
            regs_nxt.acc    = m;
            regs_nxt.status = with_nz(p, m);
         end
         OP_LDX: begin
            regs_nxt.xreg   = m;
            regs_nxt.status = with_nz(p, m);
         end
         OP_LDY: begin
            regs_nxt.yreg   = m;
            regs_nxt.status = with_nz(p, m);
         end
         OP_STA: begin
            effect.mem_write = 1'b1;
            effect.mem_data  = regs_cur.acc;
         end
         OP_STX: begin
            effect.mem_write = 1'b1;
            effect.mem_data  = regs_cur.xreg;
         end
         OP_STY: begin
            effect.mem_write = 1'b1;
            effect.mem_data  = regs_cur.yreg;
         end
         OP_TAX: begin
            regs_nxt.xreg   = regs_cur.acc;
            regs_nxt.status = with_nz(p, regs_cur.acc);
         end
         OP_TAY: begin
            regs_nxt.yreg   = regs_cur.acc;
            regs_nxt.status = with_nz(p, regs_cur.acc);
         end
         OP_TXA: begin
            regs_nxt.acc    = regs_cur.xreg;
            regs_nxt.status = with_nz(p, regs_cur.xreg);
         end
         OP_TYA: begin
            regs_nxt.acc    = regs_cur.yreg;
            regs_nxt.status = with_nz(p, regs_cur.yreg);
         end
         OP_TSX: begin
            regs_nxt.xreg   = regs_cur.stack_ptr;
            regs_nxt.status = with_nz(p, regs_cur.stack_ptr);
         end
         OP_TXS: regs_nxt.stack_ptr = regs_cur.xreg;
         OP_PHA: begin
            effect.mem_write          = 1'b1;
            effect.mem_write_to_stack = 1'b1;
            effect.mem_data           = regs_cur.acc;
            regs_nxt.stack_ptr        = regs_cur.stack_ptr - 8'd1;
         end
         OP_PHP: begin
            effect.mem_write          = 1'b1;
            effect.mem_write_to_stack = 1'b1;
            effect.mem_data           = p | PUSH_BITS;
            regs_nxt.stack_ptr        = regs_cur.stack_ptr - 8'd1;
         end
         OP_PLA: begin
            regs_nxt.stack_ptr = regs_cur.stack_ptr + 8'd1;
            regs_nxt.acc       = m;
            regs_nxt.status    = with_nz(p, m);
         end
         OP_PLP: begin
            regs_nxt.stack_ptr = regs_cur.stack_ptr + 8'd1;
            regs_nxt.status    = (m & PULL_MASK) | (p & PUSH_BITS);
         end
         OP_AND: begin
            regs_nxt.acc    = regs_cur.acc & m;
            regs_nxt.status = with_nz(p, regs_cur.acc & m);
         end
         OP_EOR: begin
            regs_nxt.acc    = regs_cur.acc ^ m;
            regs_nxt.status = with_nz(p, regs_cur.acc ^ m);
         end
         OP_ORA: begin
            regs_nxt.acc    = regs_cur.acc | m;
            regs_nxt.status = with_nz(p, regs_cur.acc | m);
         end
         OP_BIT: begin
            regs_nxt.status[FL_Z] = ((regs_cur.acc & m) == 8'd0);
            regs_nxt.status[FL_V] = m[6];
            regs_nxt.status[FL_N] = m[7];
         end
         OP_ADC, OP_SBC: begin
            regs_nxt.acc          = add_sum[7:0];
            regs_nxt.status       = with_nz(p, add_sum[7:0]);
            regs_nxt.status[FL_C] = add_sum[8];
            regs_nxt.status[FL_V] = add_v;
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            regs_nxt.status[FL_C] = ~cmp_diff[8];
            regs_nxt.status[FL_Z] = (cmp_reg == m);
            regs_nxt.status[FL_N] = cmp_diff[7];
         end
         OP_INC: begin
            effect.mem_write = 1'b1;
            effect.mem_data  = m + 8'd1;
            regs_nxt.status  = with_nz(p, m + 8'd1);
         end
         OP_INX: begin
            regs_nxt.xreg   = regs_cur.xreg + 8'd1;
            regs_nxt.status = with_nz(p, regs_cur.xreg + 8'd1);
         end
         OP_INY: begin
            regs_nxt.yreg   = regs_cur.yreg + 8'd1;
            regs_nxt.status = with_nz(p, regs_cur.yreg + 8'd1);
         end
         OP_DEC: begin
            effect.mem_write = 1'b1;
            effect.mem_data  = m - 8'd1;
            regs_nxt.status  = with_nz(p, m - 8'd1);
         end
         OP_DEX: begin
            regs_nxt.xreg   = regs_cur.xreg - 8'd1;
            regs_nxt.status = with_nz(p, regs_cur.xreg - 8'd1);
         end
         OP_DEY: begin
            regs_nxt.yreg   = regs_cur.yreg - 8'd1;
            regs_nxt.status = with_nz(p, regs_cur.yreg - 8'd1);
         end
         OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
            regs_nxt.acc          = sh_res;
            regs_nxt.status       = with_nz(p, sh_res);
            regs_nxt.status[FL_C] = sh_cout;
         end
         OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
            effect.mem_write      = 1'b1;
            effect.mem_data       = sh_res;
            regs_nxt.status       = with_nz(p, sh_res);
            regs_nxt.status[FL_C] = sh_cout;
         end
         OP_JMP: begin
            effect.pc_load = 1'b1;
            effect.pc_next = operand;
         end
         OP_BCC: take = ~p[FL_C];
         OP_BCS: take = p[FL_C];
         OP_BEQ: take = p[FL_Z];
         OP_BMI: take = p[FL_N];
         OP_BNE: take = ~p[FL_Z];
         OP_BPL: take = ~p[FL_N];
         OP_BVC: take = ~p[FL_V];
         OP_BVS: take = p[FL_V];
         OP_CLC: regs_nxt.status[FL_C] = 1'b0;
         OP_CLD: regs_nxt.status[FL_D] = 1'b0;
         OP_CLI: regs_nxt.status[FL_I] = 1'b0;
         OP_CLV: regs_nxt.status[FL_V] = 1'b0;
         OP_SEC: regs_nxt.status[FL_C] = 1'b1;
         OP_SED: regs_nxt.status[FL_D] = 1'b1;
         OP_SEI: regs_nxt.status[FL_I] = 1'b1;
         default: ;
      endcase

      if (take) begin
         effect.pc_load      = 1'b1;
         effect.pc_next      = br_target;
         effect.extra_cycles = (br_target[15:8] != pc_now[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
      end
   end

endmodule

[hw/rtl/cpu6502_execute_unit.sv]
`timescale 1ns / 1ps
// 6502 execute unit: one instruction per request on the A, X, Y, SP and P registers.
// Request channel (req_*): operation code, fetched operand byte (or JMP target),
// signed branch offset and current PC. Response channel (rsp_*): all registers
// after the instruction, the memory or stack write it asks for, the PC load and
// the extra cycles of a taken branch. Every request gives exactly one response.
// A request is registered in the input register, executed there against the
// register file, and its response is registered in the output register.
// Throughput: one request per cycle while responses are taken; the register
// file feeds back to the execute logic, so back-to-back instructions see
// each other's results.
// A stalled response holds in the output register; the input register still
// takes a request while the response waits, and req_tready drops only once
// both registers are full.
// Reset (synchronous, active high) clears both valids and sets A = X = Y = 0,
// SP = 0xFD and P = 0x24.
module cpu6502_execute_unit
   import c65x_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] func, [21:6] operand, [29:22] branch_offset, [45:30] pc_now
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] acc_out, [15:8] xreg_out, [23:16] yreg_out, [31:24] stack_ptr_out,
   // [39:32] status_out, [40] mem_write, [41] mem_write_to_stack,
   // [49:42] mem_data, [50] pc_load, [66:51] pc_next, [68:67] extra_cycles
   output logic [71:0] rsp_tdata
);

   logic              in_valid_ff, in_valid_in;
   func_type          func_ff;
   logic [15:0]       operand_ff;
   logic signed [7:0] offset_ff;
   logic [15:0]       pc_ff;
   logic              out_valid_ff, out_valid_in;
   logic [71:0]       out_data_ff;
   regs_type          regs_ff;
   regs_type          regs_nxt;
   effect_type        effect;
   logic              advance;
   logic              req_take;

   c65x_alu u_alu (
      .func          (func_ff),
      .operand       (operand_ff),
      .branch_offset (offset_ff),
      .pc_now        (pc_ff),
      .regs_cur      (regs_ff),
      .regs_nxt      (regs_nxt),
      .effect        (effect)
   );

   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         regs_ff.acc        <= 8'd0;
         regs_ff.xreg       <= 8'd0;
         regs_ff.yreg       <= 8'd0;
         regs_ff.stack_ptr  <= SP_RESET;
         regs_ff.status     <= STATUS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            regs_ff <= regs_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff    <= req_tdata[5:0];
         operand_ff <= req_tdata[21:6];
         offset_ff  <= req_tdata[29:22];
         pc_ff      <= req_tdata[45:30];
      end
      if (advance) begin
         out_data_ff <= {3'd0,
                         effect.extra_cycles,
                         effect.pc_next,
                         effect.pc_load,
                         effect.mem_data,
                         effect.mem_write_to_stack,
                         effect.mem_write,
                         regs_nxt.status,
                         regs_nxt.stack_ptr,
                         regs_nxt.yreg,
                         regs_nxt.xreg,
                         regs_nxt.acc};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

[dv/cpu6502_execute_unit_tb.sv]
`timescale 1ns / 1ps
module cpu6502_execute_unit_tb;
   import c65x_pkg::*;

   typedef struct {
      func_type          func;
      logic [15:0]       operand;
      logic signed [7:0] offset;
      logic [15:0]       pc;
   } instr_type;

   typedef struct {
      regs_type   regs;
      effect_type fx;
   } outcome_type;

   // Tracks the architectural registers and holds the outcomes still owed by the block.
   class exec_scoreboard_type;
      regs_type    arch;
      effect_type  fx;
      outcome_type outcome_q[$];
      int          errors;
      int          seen;

      function new();
         arch.acc       = 8'h00;
         arch.xreg      = 8'h00;
         arch.yreg      = 8'h00;
         arch.stack_ptr = 8'hFD;
         arch.status    = 8'h24;
         errors         = 0;
         seen           = 0;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function logic [7:0] nz(input logic [7:0] v);
         arch.status[FL_Z] = (v == 8'h00);
         arch.status[FL_N] = v[7];
         return v;
      endfunction

      function void mem_store(input logic [7:0] d, input logic stack);
         fx.mem_write          = 1'b1;
         fx.mem_write_to_stack = stack;
         fx.mem_data           = d;
      endfunction

      function void add_carry(input logic [7:0] m);
         logic [8:0] sum;
         logic [7:0] r;
         sum = {1'b0, arch.acc} + {1'b0, m} + {8'h00, arch.status[FL_C]};
         r   = sum[7:0];
         arch.status[FL_C] = sum[8];
         arch.status[FL_V] = ~(arch.acc[7] ^ m[7]) & (arch.acc[7] ^ r[7]);
         arch.acc = nz(r);
      endfunction

      function void compare_reg(input logic [7:0] rv, input logic [7:0] m);
         logic [7:0] diff;
         diff = rv - m;
         arch.status[FL_C] = (rv >= m);
         arch.status[FL_Z] = (rv == m);
         arch.status[FL_N] = diff[7];
      endfunction

      function logic [7:0] shift_byte(input func_type f, input logic [7:0] v);
         logic       cin;
         logic       rot;
         logic [7:0] r;
         cin = arch.status[FL_C];
         rot = (f == OP_ROL_A) || (f == OP_ROL_M) || (f == OP_ROR_A) || (f == OP_ROR_M);
         if (f == OP_ASL_A || f == OP_ASL_M || f == OP_ROL_A || f == OP_ROL_M) begin
            arch.status[FL_C] = v[7];
            r = {v[6:0], rot & cin};
         end else begin
            arch.status[FL_C] = v[0];
            r = {rot & cin, v[7:1]};
         end
         return nz(r);
      endfunction

      function void note_request(input instr_type it);
         logic [7:0]  m;
         logic [15:0] tgt;
         logic        take;
         outcome_type o;
         m    = it.operand[7:0];
         take = 1'b0;
         fx   = '0;
         case (it.func)
            OP_LDA: arch.acc  = nz(m);
            OP_LDX: arch.xreg = nz(m);
            OP_LDY: arch.yreg = nz(m);
            OP_STA: mem_store(arch.acc, 1'b0);
            OP_STX: mem_store(arch.xreg, 1'b0);
            OP_STY: mem_store(arch.yreg, 1'b0);
            OP_TAX: arch.xreg = nz(arch.acc);
            OP_TAY: arch.yreg = nz(arch.acc);
            OP_TXA: arch.acc  = nz(arch.xreg);
            OP_TYA: arch.acc  = nz(arch.yreg);
            OP_TSX: arch.xreg = nz(arch.stack_ptr);
            OP_TXS: arch.stack_ptr = arch.xreg;
            OP_PHA: begin
               mem_store(arch.acc, 1'b1);
               arch.stack_ptr = arch.stack_ptr - 8'd1;
            end
            OP_PHP: begin
               mem_store(arch.status | PUSH_BITS, 1'b1);
               arch.stack_ptr = arch.stack_ptr - 8'd1;
            end
            OP_PLA: begin
               arch.stack_ptr = arch.stack_ptr + 8'd1;
               arch.acc = nz(m);
            end
            OP_PLP: begin
               arch.stack_ptr = arch.stack_ptr + 8'd1;
               arch.status = (m & PULL_MASK) | (arch.status & PUSH_BITS);
            end
            OP_AND: arch.acc = nz(arch.acc & m);
            OP_EOR: arch.acc = nz(arch.acc ^ m);
            OP_ORA: arch.acc = nz(arch.acc | m);
            OP_BIT: begin
               arch.status[FL_Z] = ((arch.acc & m) == 8'h00);
               arch.status[FL_V] = m[6];
               arch.status[FL_N] = m[7];
            end
            OP_ADC: add_carry(m);
            OP_SBC: add_carry(~m);
            OP_CMP: compare_reg(arch.acc, m);
            OP_CPX: compare_reg(arch.xreg, m);
            OP_CPY: compare_reg(arch.yreg, m);
            OP_INC: mem_store(nz(m + 8'd1), 1'b0);
            OP_INX: arch.xreg = nz(arch.xreg + 8'd1);
            OP_INY: arch.yreg = nz(arch.yreg + 8'd1);
            OP_DEC: mem_store(nz(m - 8'd1), 1'b0);
            OP_DEX: arch.xreg = nz(arch.xreg - 8'd1);
            OP_DEY: arch.yreg = nz(arch.yreg - 8'd1);
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A:
               arch.acc = shift_byte(it.func, arch.acc);
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M:
               mem_store(shift_byte(it.func, m), 1'b0);
            OP_JMP: begin
               fx.pc_load = 1'b1;
               fx.pc_next = it.operand;
            end
            OP_BCC: take = !arch.status[FL_C];
            OP_BCS: take = arch.status[FL_C];
            OP_BEQ: take = arch.status[FL_Z];
            OP_BMI: take = arch.status[FL_N];
            OP_BNE: take = !arch.status[FL_Z];
            OP_BPL: take = !arch.status[FL_N];
            OP_BVC: take = !arch.status[FL_V];
            OP_BVS: take = arch.status[FL_V];
            OP_CLC: arch.status[FL_C] = 1'b0;
            OP_CLD: arch.status[FL_D] = 1'b0;
            OP_CLI: arch.status[FL_I] = 1'b0;
            OP_CLV: arch.status[FL_V] = 1'b0;
            OP_SEC: arch.status[FL_C] = 1'b1;
            OP_SED: arch.status[FL_D] = 1'b1;
            OP_SEI: arch.status[FL_I] = 1'b1;
            default: ;
         endcase
         if (take) begin
            tgt = it.pc + {{8{it.offset[7]}}, it.offset};
            fx.pc_load      = 1'b1;
            fx.pc_next      = tgt;
            fx.extra_cycles = (tgt[15:8] != it.pc[15:8]) ? EXTRA_PAGE : EXTRA_TAKEN;
         end
         o.regs = arch;
         o.fx   = fx;
         outcome_q.push_back(o);
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 60)
            $display("%0t ns: response %0d: %s", $time, seen, msg);
      endtask

      task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
         if (got !== want)
            report($sformatf("%s is %h, %h predicted", name, got, want));
      endtask

      task check_response(input logic [71:0] d);
         outcome_type w;
         seen++;
         if (outcome_q.size() == 0) begin
            report("response arrived with no request outstanding");
         end else begin
            w = outcome_q.pop_front();
            compare_field("acc_out", 16'(d[7:0]), 16'(w.regs.acc));
            compare_field("xreg_out", 16'(d[15:8]), 16'(w.regs.xreg));
            compare_field("yreg_out", 16'(d[23:16]), 16'(w.regs.yreg));
            compare_field("stack_ptr_out", 16'(d[31:24]), 16'(w.regs.stack_ptr));
            compare_field("status_out", 16'(d[39:32]), 16'(w.regs.status));
            compare_field("mem_write", 16'(d[40]), 16'(w.fx.mem_write));
            compare_field("mem_write_to_stack", 16'(d[41]),
                          16'(w.fx.mem_write_to_stack));
            compare_field("mem_data", 16'(d[49:42]), 16'(w.fx.mem_data));
            compare_field("pc_load", 16'(d[50]), 16'(w.fx.pc_load));
            compare_field("pc_next", d[66:51], w.fx.pc_next);
            compare_field("extra_cycles", 16'(d[68:67]), 16'(w.fx.extra_cycles));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   exec_scoreboard_type sb;
   bit                  idle_gaps;
   int                  rsp_hold;

   cpu6502_execute_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input instr_type it);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {2'b00, it.pc, it.offset, it.operand, it.func};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(it);
   endtask

   task automatic issue(input func_type f, input logic [15:0] operand = 16'h0000,
                        input logic [7:0] offset = 8'h00, input logic [15:0] pc = 16'h0200);
      instr_type it;
      it.func    = f;
      it.operand = operand;
      it.offset  = offset;
      it.pc      = pc;
      send_request(it);
   endtask

   task automatic collect_responses();
      int gap;
      forever begin
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = pick_gap();
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_tready = 1'b0;
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_response(rsp_tdata);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      issue(OP_LDA, 16'h0000);
      issue(OP_LDA, 16'hFF80);
      issue(OP_LDX, 16'h0000);
      issue(OP_TXS);
      issue(OP_PHP);
      issue(OP_PLA, 16'hAB7F);
      issue(OP_PLP, 16'h00FF);
      issue(OP_PLP, 16'h0000);
      issue(OP_LDX, 16'h00FF);
      issue(OP_TXS);
      issue(OP_PLA, 16'h0000);
      issue(OP_LDA, 16'h007F);
      issue(OP_ADC, 16'h0001);
      issue(OP_SEC);
      issue(OP_SBC, 16'h0001);
      issue(OP_ADC, 16'hFFFF);
      issue(OP_CMP, 16'h007F);
      issue(OP_BIT, 16'h00C0);
      issue(OP_INC, 16'h00FF);
      issue(OP_DEC, 16'h0000);
      issue(OP_SEC);
      issue(OP_ROR_M, 16'h0001);
      issue(OP_BCS, 16'h0000, 8'h80, 16'h0010);
      issue(OP_BCS, 16'h0000, 8'h7F, 16'hFFF0);
      issue(OP_BCC, 16'h0000, 8'h05, 16'h1234);
      issue(OP_JMP, 16'hFFFF);
      issue(func_type'(63));
   endtask

   task automatic send_random(input int count, input bit sweep);
      instr_type it;
      int        r;
      for (int i = 0; i < count; i++) begin
         it.func = sweep ? func_type'(i % 64) : func_type'($urandom_range(0, 63));
         r = $urandom_range(0, 9);
         case (r)
            0: it.operand = {8'($urandom_range(0, 255)), 8'h00};
            1: it.operand = {8'($urandom_range(0, 255)), 8'hFF};
            2: it.operand = {8'($urandom_range(0, 255)), 8'h80};
            3: it.operand = {8'($urandom_range(0, 255)), 8'h7F};
            default: it.operand = 16'($urandom_range(0, 65535));
         endcase
         it.offset = 8'($urandom_range(0, 255));
         r = $urandom_range(0, 9);
         if (r < 2)
            it.pc = {8'($urandom_range(0, 255)), 8'h80 + 8'($urandom_range(0, 127))};
         else if (r < 3)
            it.pc = {8'hFF, 8'($urandom_range(0, 255))};
         else if (r < 4)
            it.pc = {8'h00, 8'($urandom_range(0, 255))};
         else
            it.pc = 16'($urandom_range(0, 65535));
         send_request(it);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      idle_gaps  = 1'b1;
      rsp_hold   = 0;
      sb         = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         collect_responses();
      join_none

      run_directed();
      send_random(64, 1'b1);
      send_random(450, 1'b0);

      // receiver stalls long while requests keep coming
      rsp_hold  = 150;
      idle_gaps = 1'b0;
      send_random(60, 1'b0);
      idle_gaps = 1'b1;

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();

      idle_gaps = 1'b0;
      send_random(250, 1'b0);
      idle_gaps = 1'b1;
      send_random(300, 1'b0);

      rsp_hold  = 100;
      idle_gaps = 1'b0;
      send_random(40, 1'b0);
      idle_gaps = 1'b1;
      send_random(240, 1'b0);

      @(negedge clock);
      req_tvalid = 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
